// ===== hdl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg - shared types and codes of the rational arithmetic unit
// Beat payloads of the command and result channels, operation and error codes.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam logic [2:0] MODE_NORM   = 3'd0;
  localparam logic [2:0] MODE_ADD    = 3'd1;
  localparam logic [2:0] MODE_MUL    = 3'd2;
  localparam logic [2:0] MODE_NEG    = 3'd3;
  localparam logic [2:0] MODE_EQ     = 3'd4;
  localparam logic [2:0] MODE_LT     = 3'd5;
  localparam logic [2:0] MODE_LE     = 3'd6;
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_ZERO_DEN = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               compare_true;
    logic [1:0]         error_code;
  } res_t;

endpackage

// ===== hdl/rau_if.sv =====
// ----------------------------------------------------------------------------
// rau_cmd_if / rau_res_if - valid/ready channels of the rational unit
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface rau_cmd_if import rau_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rau_res_if import rau_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit - fraction arithmetic with gcd reduction
// Normalize, add, multiply, negate and compare signed fractions.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one operation per beat (mode and two fractions); res returns
//   one beat per command: a canonical fraction, a compare flag, an error code.
//   A 32x32 multiplier forms the cross products one per cycle (up to three
//   of them), then binary gcd runs on 64-bit values (one step a cycle) and a
//   restoring divider divides numerator and denominator by the gcd, 64 steps
//   each; cmd.ready is low while an item is at work.
//   The result sits in an output register; the next command is taken while
//   it waits, and a finished item holds in its last state until res frees.
//   Synchronous reset clears the sequencer and res.valid.
//   WORD_BITS sets the range checked for overflow of the reduced result.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  rau_cmd_if.sink     cmd,
  rau_res_if.source   res
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_CMP, S_COMB, S_RED, S_GCD,
    S_DIVN, S_DIVD, S_FITS, S_FIN
  } state_t;

  localparam logic [63:0] LIM = 64'd1 << (WORD_BITS - 1);

  state_t      state;
  logic [2:0]  mode;
  logic [31:0] an, ad, bn, bd;
  logic        a_neg, b_neg;
  logic [63:0] p, q, dp;
  logic [63:0] rn, rd;
  logic        rneg;
  logic [63:0] x, y, g;
  logic [5:0]  k;
  logic [63:0] dv, rem;
  logic [5:0]  cnt;
  res_t        fin;

  logic [31:0] an_c, ad_c, bn_c, bd_c;
  logic        binary_c;
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;
  logic [63:0] rem_sh;
  logic        rem_ge;

  always_comb begin
    an_c = cmd.data.a_num[31] ? 32'(-cmd.data.a_num) : cmd.data.a_num;
    ad_c = cmd.data.a_den[31] ? 32'(-cmd.data.a_den) : cmd.data.a_den;
    bn_c = cmd.data.b_num[31] ? 32'(-cmd.data.b_num) : cmd.data.b_num;
    bd_c = cmd.data.b_den[31] ? 32'(-cmd.data.b_den) : cmd.data.b_den;
    binary_c = !(cmd.data.mode == MODE_NORM || cmd.data.mode == MODE_NEG);
  end

  // shared multiplier operands
  always_comb begin
    mul_x = ad;
    mul_y = bd;
    unique case (state)
      S_MUL0: begin
        mul_x = an;
        mul_y = (mode == MODE_MUL) ? bn : bd;
      end
      S_MUL1: begin
        mul_x = (mode == MODE_MUL) ? ad : bn;
        mul_y = (mode == MODE_MUL) ? bd : ad;
      end
      default: begin
        mul_x = ad;
        mul_y = bd;
      end
    endcase
  end
  assign mul_p = 64'(mul_x) * 64'(mul_y);

  assign rem_sh = {rem[62:0], dv[63]};
  assign rem_ge = rem_sh >= g;

  assign cmd.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && state != S_FIN) res.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            mode  <= cmd.data.mode;
            an    <= an_c;
            ad    <= ad_c;
            bn    <= bn_c;
            bd    <= bd_c;
            a_neg <= (cmd.data.a_num[31] ^ cmd.data.a_den[31]) && an_c != 32'd0;
            b_neg <= (cmd.data.b_num[31] ^ cmd.data.b_den[31]) && bn_c != 32'd0;
            fin   <= '0;
            if (cmd.data.mode == MODE_UNUSED) begin
              state <= S_FIN;
            end else if (ad_c == 32'd0 || (binary_c && bd_c == 32'd0)) begin
              fin.error_code <= ERR_ZERO_DEN;
              state          <= S_FIN;
            end else if (!binary_c) begin
              rn    <= {32'd0, an_c};
              rd    <= {32'd0, ad_c};
              rneg  <= ((cmd.data.a_num[31] ^ cmd.data.a_den[31]) &&
                        an_c != 32'd0) ^ (cmd.data.mode == MODE_NEG);
              state <= S_RED;
            end else begin
              state <= S_MUL0;
            end
          end
        end
        S_MUL0: begin
          p     <= mul_p;
          state <= S_MUL1;
        end
        S_MUL1: begin
          q <= mul_p;
          if (mode == MODE_MUL) begin
            rn    <= p;
            rd    <= mul_p;
            rneg  <= a_neg ^ b_neg;
            state <= S_RED;
          end else if (mode == MODE_ADD) begin
            state <= S_MUL2;
          end else begin
            state <= S_CMP;
          end
        end
        S_MUL2: begin
          dp    <= mul_p;
          state <= S_COMB;
        end
        S_CMP: begin
          unique case (mode)
            MODE_EQ: fin.compare_true <= (a_neg == b_neg) && p == q;
            MODE_LT: fin.compare_true <= (a_neg != b_neg) ? a_neg :
                                         (a_neg ? p > q : p < q);
            default: fin.compare_true <= ((a_neg != b_neg) ? a_neg :
                                          (a_neg ? p > q : p < q)) ||
                                         ((a_neg == b_neg) && p == q);
          endcase
          state <= S_FIN;
        end
        S_COMB: begin
          rd <= dp;
          if (a_neg == b_neg) begin
            rn   <= p + q;
            rneg <= a_neg;
          end else if (p >= q) begin
            rn   <= p - q;
            rneg <= a_neg;
          end else begin
            rn   <= q - p;
            rneg <= b_neg;
          end
          state <= S_RED;
        end
        S_RED: begin
          if (rn == 64'd0) begin
            rd    <= 64'd1;
            rneg  <= 1'b0;
            state <= S_FITS;
          end else begin
            x     <= rn;
            y     <= rd;
            k     <= '0;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          // binary gcd: one shift or subtract per cycle
          if (x == 64'd0) begin
            g     <= y << k;
            dv    <= rn;
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIVN;
          end else if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + 6'd1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x >= y) begin
            x <= x - y;
          end else begin
            y <= y - x;
          end
        end
        S_DIVN, S_DIVD: begin
          rem <= rem_ge ? rem_sh - g : rem_sh;
          dv  <= {dv[62:0], rem_ge};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            if (state == S_DIVN) begin
              rn    <= {dv[62:0], rem_ge};
              dv    <= rd;
              rem   <= '0;
              state <= S_DIVD;
            end else begin
              rd    <= {dv[62:0], rem_ge};
              state <= S_FITS;
            end
          end
        end
        S_FITS: begin
          if (rd > LIM - 64'd1 || (rneg ? rn > LIM : rn > LIM - 64'd1)) begin
            fin.error_code <= ERR_OVERFLOW;
          end else begin
            fin.res_num <= rneg ? 32'(-rn) : rn[31:0];
            fin.res_den <= rd[30:0];
          end
          state <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (!res.valid || res.ready) begin
            res.data  <= fin;
            res.valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the rational arithmetic unit
// Drives fraction commands through the valid/ready command channel and checks
// every result beat against a fraction predictor with exact 64-bit
// intermediates. Idling and stalling change from phase to phase, and one long
// receiver hold-off backs the unit up.
// ----------------------------------------------------------------------------
module tb_top import rau_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int PRESSURE_LEN   = 600;

  typedef struct {
    bit          neg;
    logic [63:0] n;
    logic [63:0] d;
  } fraction_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rau_cmd_if cmd ();
  rau_res_if res ();

  rational_arithmetic_unit #(.WORD_BITS(32)) u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd.sink),
    .res (res.source)
  );

  always #5 clk = ~clk;

  cmd_t pending_cmds[$];
  res_t expected_results[$];
  int   sender_idle_pct = 0;
  int   recv_stall_pct  = 0;
  int   pressure_len    = 0;
  int   hold_left       = 0;
  bit   pressure_done   = 1'b0;
  bit   cmd_fire        = 1'b0;
  int   quiet_cycles    = 0;
  int   error_count     = 0;

  // ---------------------------------------------------------------- predictor
  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic fraction_t reduce_fraction(fraction_t f);
    logic [63:0] g;
    g = gcd64(f.n, f.d);
    if (g != 0) begin
      f.n = f.n / g;
      f.d = f.d / g;
    end
    if (f.n == 0) begin
      f.neg = 1'b0;
      f.d   = 64'd1;
    end
    return f;
  endfunction

  function automatic logic [63:0] magnitude(logic [31:0] v);
    return v[31] ? 64'h1_0000_0000 - {32'd0, v} : {32'd0, v};
  endfunction

  // Returns 0 on a zero denominator.
  function automatic bit canonical(logic [31:0] num, logic [31:0] den,
                                   output fraction_t f);
    f.neg = num[31] ^ den[31];
    f.n   = magnitude(num);
    f.d   = magnitude(den);
    if (f.d == 0) return 1'b0;
    f = reduce_fraction(f);
    return 1'b1;
  endfunction

  function automatic bit frac_less(fraction_t a, fraction_t b);
    logic [63:0] p, q;
    p = a.n * b.d;
    q = b.n * a.d;
    if (a.neg != b.neg) return a.neg;
    return a.neg ? (p > q) : (p < q);
  endfunction

  function automatic bit frac_equal(fraction_t a, fraction_t b);
    return a.neg == b.neg && a.n == b.n && a.d == b.d;
  endfunction

  function automatic res_t predict_fraction(cmd_t c);
    res_t      r;
    fraction_t a, b, y;
    bit        ok_a, ok_b, binary_op;
    logic [63:0] p, q, lim;
    r = '0;
    if (c.mode == MODE_UNUSED) return r;
    binary_op = !(c.mode == MODE_NORM || c.mode == MODE_NEG);
    ok_b = 1'b1;
    ok_a = canonical(c.a_num, c.a_den, a);
    if (binary_op) ok_b = canonical(c.b_num, c.b_den, b);
    if (!ok_a || !ok_b) begin
      r.error_code = ERR_ZERO_DEN;
      return r;
    end
    case (c.mode)
      MODE_EQ: begin
        r.compare_true = frac_equal(a, b);
        return r;
      end
      MODE_LT: begin
        r.compare_true = frac_less(a, b);
        return r;
      end
      MODE_LE: begin
        r.compare_true = frac_less(a, b) || frac_equal(a, b);
        return r;
      end
      MODE_NORM: y = a;
      MODE_NEG: begin
        y = a;
        y.neg = !y.neg;
        y = reduce_fraction(y);
      end
      MODE_MUL: begin
        y.neg = a.neg ^ b.neg;
        y.n   = a.n * b.n;
        y.d   = a.d * b.d;
        y = reduce_fraction(y);
      end
      default: begin
        p = a.n * b.d;
        q = b.n * a.d;
        if (a.neg == b.neg) begin
          y.n = p + q;
          y.neg = a.neg;
        end else if (p >= q) begin
          y.n = p - q;
          y.neg = a.neg;
        end else begin
          y.n = q - p;
          y.neg = b.neg;
        end
        y.d = a.d * b.d;
        y = reduce_fraction(y);
      end
    endcase
    lim = 64'd1 << 31;
    if (y.d > lim - 1 || y.d == 0 || y.n > (y.neg ? lim : lim - 1)) begin
      r.error_code = ERR_OVERFLOW;
      return r;
    end
    r.res_num = y.neg ? -y.n[31:0] : y.n[31:0];
    r.res_den = y.d[30:0];
    return r;
  endfunction

  // ------------------------------------------------------------ command driver
  always @(negedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (cmd.valid && !cmd_fire) begin
      cmd.valid <= 1'b1;    // hold the offered beat
    end else if (pending_cmds.size() > 0 &&
                 $urandom_range(99) >= sender_idle_pct) begin
      cmd.valid <= 1'b1;
      cmd.data  <= pending_cmds[0];
    end else begin
      cmd.valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------- result receiver
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (!pressure_done && pressure_len > 0) begin
      pressure_done <= 1'b1;
      hold_left     <= pressure_len;
      res.ready     <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ------------------------------------------------------ acceptance and check
  always @(posedge clk) begin
    res_t got, want;
    cmd_fire <= 1'b0;
    if (!rst) begin
      if (cmd.valid && cmd.ready) begin
        cmd_fire <= 1'b1;
        expected_results.push_back(predict_fraction(pending_cmds.pop_front()));
      end
      if (res.valid && res.ready) begin
        got = res.data;
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: %p", got);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.res_num !== want.res_num) begin
            $error("res_num expected %0d got %0d", want.res_num, got.res_num);
            error_count++;
          end
          if (got.res_den !== want.res_den) begin
            $error("res_den expected %0d got %0d", want.res_den, got.res_den);
            error_count++;
          end
          if (got.compare_true !== want.compare_true) begin
            $error("compare_true expected %0b got %0b",
                   want.compare_true, got.compare_true);
            error_count++;
          end
          if (got.error_code !== want.error_code) begin
            $error("error_code expected %0d got %0d",
                   want.error_code, got.error_code);
            error_count++;
          end
        end
      end
      if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ----------------------------------------------------------------- stimulus
  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0:       return $urandom_range(40) - 20;
      1:       return $urandom_range(2000) - 1000;
      2: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'd1;
        endcase
      end
      3:       return $urandom_range(65536) - 32768;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_den();
    if ($urandom_range(29) == 0) return 32'd0;
    return rand_word();
  endfunction

  task automatic add_cmd(logic [2:0] m, logic [31:0] an, logic [31:0] ad,
                         logic [31:0] bn, logic [31:0] bd);
    cmd_t c;
    c.mode = m;
    c.a_num = an;
    c.a_den = ad;
    c.b_num = bn;
    c.b_den = bd;
    pending_cmds.push_back(c);
  endtask

  task automatic add_random_cmd();
    logic [2:0]  m;
    logic [31:0] an, ad;
    m  = ($urandom_range(49) == 0) ? MODE_UNUSED : 3'($urandom_range(6));
    an = rand_word();
    ad = rand_den();
    // equal operands now and then, so compares also see ties
    if ($urandom_range(7) == 0) add_cmd(m, an, ad, an, ad);
    else add_cmd(m, an, ad, rand_word(), rand_den());
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() > 0 || expected_results.size() > 0) @(posedge clk);
  endtask

  initial begin
    cmd.valid = 1'b0;
    cmd.data  = '0;
    res.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    add_cmd(MODE_NORM, 6, -4, 0, 0);
    add_cmd(MODE_NORM, 0, -7, 0, 0);
    add_cmd(MODE_NORM, 32'h8000_0000, 1, 0, 0);
    add_cmd(MODE_NORM, 32'h8000_0000, 32'h8000_0000, 0, 0);
    add_cmd(MODE_NORM, 1, 32'h8000_0000, 5, 5);
    add_cmd(MODE_NORM, 3, 0, 1, 1);
    add_cmd(MODE_ADD, 1, 2, 1, 3);
    add_cmd(MODE_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
    add_cmd(MODE_ADD, 1, 2, -1, 2);
    add_cmd(MODE_ADD, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFE);
    add_cmd(MODE_MUL, -2, 3, 9, 4);
    add_cmd(MODE_MUL, 32'h8000_0000, 1, -1, 1);
    add_cmd(MODE_MUL, 1, 2, 3, 0);
    add_cmd(MODE_NEG, 32'h8000_0000, 1, 0, 0);
    add_cmd(MODE_NEG, 0, 5, 0, 0);
    add_cmd(MODE_NEG, 32'h7FFF_FFFF, -3, 7, 0);
    add_cmd(MODE_EQ, 2, 4, -3, -6);
    add_cmd(MODE_EQ, 0, 3, 0, -9);
    add_cmd(MODE_LT, -1, 2, -1, 3);
    add_cmd(MODE_LT, 1, 3, 1, 2);
    add_cmd(MODE_LT, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1);
    add_cmd(MODE_LE, 5, 7, 10, 14);
    add_cmd(MODE_LE, 3, 0, 1, 1);
    add_cmd(MODE_UNUSED, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0);
    wait_idle();

    // pressure: the receiver holds off while commands keep coming
    pressure_len = PRESSURE_LEN;
    repeat (60) add_random_cmd();
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin sender_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      repeat (205) add_random_cmd();
      wait_idle();
    end
    sender_idle_pct = 0;
    recv_stall_pct  = 0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
